### rtl/core/point_transform_z_clip_defines.svh
// ---------------------------------------------------------------------------
// point_transform_z_clip assertion macros
// Concurrent check wrappers, clocked on clk; compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef POINT_TRANSFORM_Z_CLIP_DEFINES_SVH
`define POINT_TRANSFORM_Z_CLIP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check that holds outside reset
`define PTZ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ptz assertion failed");
// check that also covers reset behavior
`define PTZ_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ptz reset assertion failed");
`else
`define PTZ_ASSERT(lbl, prop)
`define PTZ_ASSERT_RST(lbl, prop)
`endif

`endif

### rtl/core/ptz_pkg.sv
// ---------------------------------------------------------------------------
// ptz_pkg
// Shared widths, codes, types and arithmetic helpers of the point transform.
// ---------------------------------------------------------------------------
package ptz_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W - FRAC_BITS;
  localparam int SUM_W      = PROD_W + 2;
  localparam int NUM_W      = DATA_W + FRAC_BITS;
  localparam int DIV_LAT    = NUM_W + 2;
  localparam int IDX_W      = 4;
  localparam int MAT_N      = 16;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;
  localparam int RESQ_DEPTH = 2;

  localparam logic signed [DATA_W-1:0] ONE_FX     = DATA_W'(1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] NEG_ONE_FX = -ONE_FX;
  localparam logic signed [DATA_W-1:0] S_MAX      = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN      = {1'b1, {(DATA_W-1){1'b0}}};

  // opcodes and matrix selects
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_XFORM    = 1'b1;
  localparam logic SEL_VIEW    = 1'b0;
  localparam logic SEL_FRUSTUM = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic                     matrix_select;
    logic [IDX_W-1:0]         coeff_index;
    logic signed [DATA_W-1:0] coeff_value;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] point_z;
  } ptz_in_t;

  typedef struct packed {
    logic                     clipped;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
  } ptz_out_t;

  // coefficient load that rides along the pipeline
  typedef struct packed {
    logic                     is_load;
    logic                     sel;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] val;
  } ld_t;

  typedef struct packed {
    ld_t                      ld;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } pass_t;

  typedef struct packed {
    logic stall;
    logic res_push;
  } ptz_stat_t;

  // exact product floored to FRAC_BITS fraction bits
  function automatic logic signed [PROD_W-1:0] mul_floor(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [2*DATA_W-1:0] p;
    p = a * b;
    return p[2*DATA_W-1:FRAC_BITS];
  endfunction

  // saturate a sum to the data width
  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1);
    if (fits) return v[DATA_W-1:0];
    return v[SUM_W-1] ? S_MIN : S_MAX;
  endfunction

endpackage

### rtl/core/ptz_div.sv
// ---------------------------------------------------------------------------
// ptz_div
// Pipelined signed divider, one quotient bit per stage, saturating result.
// ---------------------------------------------------------------------------
module ptz_div import ptz_pkg::*; (
  input  logic                     clk,
  input  logic                     adv,
  input  logic signed [NUM_W-1:0]  num,
  input  logic signed [DATA_W-1:0] den,
  output logic signed [DATA_W-1:0] quo
);

  logic [DATA_W-1:0] rem_r   [NUM_W+1];
  logic [NUM_W-1:0]  dq_r    [NUM_W+1];
  logic [DATA_W-1:0] dv_r    [NUM_W+1];
  logic              ng_r    [NUM_W+1];
  logic [DATA_W-1:0] rem_nxt [NUM_W+1];
  logic [NUM_W-1:0]  dq_nxt  [NUM_W+1];
  logic [DATA_W-1:0] dv_nxt  [NUM_W+1];
  logic              ng_nxt  [NUM_W+1];
  logic signed [DATA_W-1:0] quo_r;
  logic signed [DATA_W-1:0] quo_nxt;
  logic [NUM_W-1:0]  q_mag;
  logic              pos_fit;
  logic              neg_fit;

  // magnitudes in, then one restoring step per stage
  always_comb begin
    logic [DATA_W:0] trial;
    logic            fit;
    rem_nxt[0] = '0;
    dq_nxt[0]  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dv_nxt[0]  = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
    ng_nxt[0]  = num[NUM_W-1] ^ den[DATA_W-1];
    for (int s = 0; s < NUM_W; s++) begin
      trial = {rem_r[s], dq_r[s][NUM_W-1]};
      fit   = trial >= {1'b0, dv_r[s]};
      rem_nxt[s+1] = fit ? DATA_W'(trial - {1'b0, dv_r[s]}) : trial[DATA_W-1:0];
      dq_nxt[s+1]  = {dq_r[s][NUM_W-2:0], fit};
      dv_nxt[s+1]  = dv_r[s];
      ng_nxt[s+1]  = ng_r[s];
    end
  end

  // sign and saturation of the final quotient
  always_comb begin
    q_mag   = dq_r[NUM_W];
    pos_fit = q_mag[NUM_W-1:DATA_W-1] == '0;
    neg_fit = (q_mag[NUM_W-1:DATA_W] == '0) &&
              (!q_mag[DATA_W-1] || (q_mag[DATA_W-2:0] == '0));
    if (ng_r[NUM_W]) begin
      quo_nxt = neg_fit ? -$signed(q_mag[DATA_W-1:0]) : S_MIN;
    end else begin
      quo_nxt = pos_fit ? $signed(q_mag[DATA_W-1:0]) : S_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s <= NUM_W; s++) begin
        rem_r[s] <= rem_nxt[s];
        dq_r[s]  <= dq_nxt[s];
        dv_r[s]  <= dv_nxt[s];
        ng_r[s]  <= ng_nxt[s];
      end
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

### rtl/core/ptz_pass.sv
// ---------------------------------------------------------------------------
// ptz_pass
// One transform pass: matrix store, multiply, sum, w fix and divide by w.
// ---------------------------------------------------------------------------
module ptz_pass import ptz_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  own_sel,
  input  logic  in_vld,
  input  pass_t in_item,
  output logic  out_vld,
  output pass_t out_item
);

  logic signed [DATA_W-1:0] m_r     [MAT_N];
  logic signed [PROD_W-1:0] prod_r  [3][4];
  logic signed [DATA_W-1:0] row3_r  [4];
  logic signed [DATA_W-1:0] acc_r   [4];
  logic signed [DATA_W-1:0] acc_nxt [4];
  logic signed [DATA_W-1:0] vin     [3];
  logic signed [DATA_W-1:0] quo     [3];
  ld_t  lda_r;
  ld_t  ldb_r;
  ld_t  sb_r    [DIV_LAT];
  logic vld_a_r;
  logic vld_b_r;
  logic vld_sb_r [DIV_LAT];

  assign vin[0] = in_item.x;
  assign vin[1] = in_item.y;
  assign vin[2] = in_item.z;

  // coefficient store, written in item order at the read stage
  always_ff @(posedge clk) begin
    if (adv && in_vld && in_item.ld.is_load && (in_item.ld.sel == own_sel)) begin
      m_r[in_item.ld.idx] <= in_item.ld.val;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_r[r][c] <= mul_floor(vin[r], m_r[r*4+c]);
        end
      end
      for (int c = 0; c < 4; c++) begin
        row3_r[c] <= m_r[12+c];
      end
      lda_r <= in_item.ld;
    end
  end

  // sum stage with saturation, zero w taken as one
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int c = 0; c < 4; c++) begin
      sum = SUM_W'(prod_r[0][c]) + SUM_W'(prod_r[1][c]) + SUM_W'(prod_r[2][c]) +
            SUM_W'(row3_r[c]);
      acc_nxt[c] = sat_sum(sum);
    end
    if (acc_nxt[3] == '0) acc_nxt[3] = ONE_FX;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_nxt;
      ldb_r <= lda_r;
    end
  end

  // divide x, y, z by w
  for (genvar c = 0; c < 3; c++) begin : g_div
    ptz_div u_div (
      .clk (clk),
      .adv (adv),
      .num ({acc_r[c], {FRAC_BITS{1'b0}}}),
      .den (acc_r[3]),
      .quo (quo[c])
    );
  end

  // sideband delay matching the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= ldb_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) vld_sb_r[i] <= 1'b0;
    end else if (adv) begin
      vld_a_r     <= in_vld;
      vld_b_r     <= vld_a_r;
      vld_sb_r[0] <= vld_b_r;
      for (int i = 1; i < DIV_LAT; i++) vld_sb_r[i] <= vld_sb_r[i-1];
    end
  end

  assign out_vld     = vld_sb_r[DIV_LAT-1];
  assign out_item.ld = sb_r[DIV_LAT-1];
  assign out_item.x  = quo[0];
  assign out_item.y  = quo[1];
  assign out_item.z  = quo[2];

endmodule

### rtl/core/ptz_front.sv
// ---------------------------------------------------------------------------
// ptz_front
// Request intake: registers and decodes each request for the command queue.
// ---------------------------------------------------------------------------
module ptz_front import ptz_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    full,
  input  ptz_in_t in_data,
  output logic    q_push,
  output pass_t   q_data,
  input  logic    q_full
);

  logic  vld_r;
  logic  vld_nxt;
  pass_t item_r;
  logic  accept;

  assign full   = vld_r && q_full;
  assign accept = push && !full;
  assign q_push = vld_r && !q_full;
  assign q_data = item_r;

  // holding register valid
  always_comb begin
    vld_nxt = vld_r;
    if (accept)      vld_nxt = 1'b1;
    else if (q_push) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // decode request
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.ld.is_load <= (in_data.opcode == OP_LOAD);
      item_r.ld.sel     <= in_data.matrix_select;
      item_r.ld.idx     <= in_data.coeff_index;
      item_r.ld.val     <= in_data.coeff_value;
      item_r.x          <= in_data.point_x;
      item_r.y          <= in_data.point_y;
      item_r.z          <= in_data.point_z;
    end
  end

endmodule

### rtl/core/ptz_cmd_queue.sv
// ---------------------------------------------------------------------------
// ptz_cmd_queue
// Short show-ahead queue between the front and back ends.
// ---------------------------------------------------------------------------
module ptz_cmd_queue import ptz_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  pass_t wr_data,
  output logic  full,
  input  logic  pop,
  output pass_t rd_data,
  output logic  empty
);

  pass_t              mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_AW:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full    = cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(do_pop);
    end
  end

endmodule

### rtl/core/ptz_back.sv
// ---------------------------------------------------------------------------
// ptz_back
// Execution: view pass, frustum pass, depth clip and the result queue.
// ---------------------------------------------------------------------------
module ptz_back import ptz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  input  pass_t     cmd_data,
  output logic      cmd_pop,
  output logic      empty,
  input  logic      pop,
  output ptz_out_t  out_data,
  output ptz_stat_t stat
);

  logic     adv;
  logic     p1_vld;
  pass_t    p1_item;
  logic     p2_vld;
  pass_t    p2_item;
  logic     res_push;
  logic     res_pop;
  ptz_out_t res;
  ptz_out_t res_mem_r [RESQ_DEPTH];
  logic     wr_ptr_r;
  logic     rd_ptr_r;
  logic [1:0] cnt_r;

  // whole pipeline moves while the result queue has room
  assign adv     = cnt_r != 2'(RESQ_DEPTH);
  assign cmd_pop = adv && !cmd_empty;

  ptz_pass u_view (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .own_sel  (SEL_VIEW),
    .in_vld   (!cmd_empty),
    .in_item  (cmd_data),
    .out_vld  (p1_vld),
    .out_item (p1_item)
  );

  ptz_pass u_frustum (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .own_sel  (SEL_FRUSTUM),
    .in_vld   (p1_vld),
    .in_item  (p1_item),
    .out_vld  (p2_vld),
    .out_item (p2_item)
  );

  // depth clip
  always_comb begin
    res.clipped = (p2_item.z < NEG_ONE_FX) || (p2_item.z > ONE_FX);
    res.pos_x   = res.clipped ? '0 : p2_item.x;
    res.pos_y   = res.clipped ? '0 : p2_item.y;
    res.pos_z   = res.clipped ? '0 : p2_item.z;
  end

  assign res_push = adv && p2_vld && !p2_item.ld.is_load;
  assign res_pop  = pop && !empty;
  assign empty    = cnt_r == '0;
  assign out_data = res_mem_r[rd_ptr_r];

  // result queue
  always_ff @(posedge clk) begin
    if (res_push) res_mem_r[wr_ptr_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (res_push) wr_ptr_r <= !wr_ptr_r;
      if (res_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(res_push) - 2'(res_pop);
    end
  end

  assign stat.stall    = !adv;
  assign stat.res_push = res_push;

endmodule

### rtl/core/point_transform_z_clip.sv
// ---------------------------------------------------------------------------
// point_transform_z_clip
// Two-pass point transform with divide by w and depth clip, Q16.16.
// ---------------------------------------------------------------------------
// channel   ports                          handshake
// input     push, full, in_data            taken when push && !full
// result    empty, pop, out_data           taken when pop && !empty
// config    cfg_we, cfg_wdata              written when cfg_we
//
// one request per cycle sustained while the result queue has room; each pass
// is a multiply stage, a sum stage and a 50-stage divider, and a point goes
// through the intake register, the command queue and both passes to its result
// loads give no result but still travel the pipeline to keep matrix order
// reset clears queues and valid bits; matrices hold garbage until loaded
// a full result queue stalls the whole back end; the command queue absorbs it
`include "point_transform_z_clip_defines.svh"

module point_transform_z_clip import ptz_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  ptz_in_t                  in_data,
  output logic                     empty,
  input  logic                     pop,
  output ptz_out_t                 out_data,
  input  logic                     cfg_we,
  input  logic signed [DATA_W-1:0] cfg_wdata
);

  logic      q_push;
  pass_t     q_wdata;
  logic      q_full;
  logic      q_pop;
  pass_t     q_rdata;
  logic      q_empty;
  ptz_stat_t back_stat;
  logic signed [DATA_W-1:0] anno_scale_r;

  // annotation scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anno_scale_r <= ONE_FX;
    end else if (cfg_we) begin
      anno_scale_r <= cfg_wdata;
    end
  end

  ptz_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  ptz_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  ptz_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd_data  (q_rdata),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .stat      (back_stat)
  );

  // checks
  `PTZ_ASSERT_RST(a_reset_clean, !rst_n |=> !full && empty && (anno_scale_r == ONE_FX))
  `PTZ_ASSERT(a_full_needs_queue_full, full |-> q_full)
  `PTZ_ASSERT(a_stall_has_result, back_stat.stall |-> !empty && !back_stat.res_push)
  `PTZ_ASSERT(a_cmd_pop_nonempty, q_pop |-> !q_empty)

endmodule
